FILE: rtl/core/spat_pkg.sv
// ----------------------------------------------------------------------------
// spat_pkg: shared types and constants
// Operation codes, configuration register indexes and the command/status
// bundle between the sequencer and the datapath of the sorted peer table.
// ----------------------------------------------------------------------------
package spat_pkg;

  localparam int unsigned MaxPeers    = 16;
  localparam int unsigned AddrWidth   = 32;
  localparam int unsigned SeqWidth    = 8;
  localparam int unsigned KindWidth   = 3;
  localparam int unsigned CfgIdxWidth = 2;

  // operation codes
  localparam logic [KindWidth-1:0] KindInsert = 3'd0;
  localparam logic [KindWidth-1:0] KindRemove = 3'd1;
  localparam logic [KindWidth-1:0] KindLookup = 3'd2;
  localparam logic [KindWidth-1:0] KindNext   = 3'd3;
  localparam logic [KindWidth-1:0] KindClean  = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgSelf      = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgWarmboot  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgBroadcast = 2'd2;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_RD_PTR,
    CMD_RD_PREV,
    CMD_RD_NEXT,
    CMD_PTR_INC,
    CMD_SET_POS,
    CMD_SH_WR,
    CMD_INS_WR,
    CMD_RM_WR,
    CMD_DEC,
    CMD_HIT,
    CMD_SET_NEXT,
    CMD_CL_WR,
    CMD_CL_END,
    CMD_LIMIT
  } dp_cmd_e;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic                 full;
    logic                 reserved;
    logic                 at_end;
    logic                 ptr_last;
    logic                 idx_bad;
    logic                 addr_eq;
    logic                 addr_lt;
    logic                 at_pos;
  } dp_status_t;

endpackage

FILE: rtl/core/spat_datapath.sv
// ----------------------------------------------------------------------------
// spat_datapath: entry storage and pointers
// Holds the sorted entry memory, the count, scan pointers and the result
// registers; executes one command from the sequencer each cycle.
// ----------------------------------------------------------------------------
module spat_datapath #(
  parameter int unsigned MaxPeers = spat_pkg::MaxPeers,
  localparam int unsigned IW = $clog2(MaxPeers),
  localparam int unsigned CW = $clog2(MaxPeers + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spat_pkg::dp_cmd_e                 cmd_i,
  input  logic                              finish_i,
  output spat_pkg::dp_status_t              status_o,
  input  logic [spat_pkg::KindWidth-1:0]    kind_i,
  input  logic [spat_pkg::AddrWidth-1:0]    address_i,
  input  logic [spat_pkg::SeqWidth-1:0]     seq_i,
  input  logic [IW-1:0]                     entry_index_i,
  input  logic [spat_pkg::AddrWidth-1:0]    self_addr_i,
  input  logic [spat_pkg::AddrWidth-1:0]    warm_addr_i,
  input  logic [spat_pkg::AddrWidth-1:0]    bcast_addr_i,
  output logic                              done_o,
  output logic                              status_bit_o,
  output logic                              hit_o,
  output logic [IW-1:0]                     hit_index_o,
  output logic [spat_pkg::SeqWidth-1:0]     hit_seq_o,
  output logic [spat_pkg::AddrWidth-1:0]    next_address_o,
  output logic [CW-1:0]                     entry_total_o,
  output logic                              is_full_o,
  output logic                              is_empty_o,
  output logic                              self_dominant_o
);

  logic [spat_pkg::AddrWidth-1:0] mem_addr [MaxPeers];
  logic [spat_pkg::SeqWidth-1:0]  mem_seq  [MaxPeers];

  logic [spat_pkg::KindWidth-1:0] kind_q;
  logic [spat_pkg::AddrWidth-1:0] addr_q, rd_addr_q, head_q, next_q;
  logic [spat_pkg::SeqWidth-1:0]  seq_q, rd_seq_q, hit_seq_q;
  logic [IW-1:0]                  idx_q, hit_idx_q;
  logic [CW-1:0]                  ptr_q, wptr_q, pos_q, count_q;
  logic                           hit_q, limit_q, done_q;

  logic [CW-1:0]                  ptr_m1, ptr_p1, rsel;
  logic [IW-1:0]                  raddr, waddr;
  logic                           we, keep;
  logic [spat_pkg::AddrWidth-1:0] wdata_addr;
  logic [spat_pkg::SeqWidth-1:0]  wdata_seq;

  assign ptr_m1 = ptr_q - CW'(1);
  assign ptr_p1 = ptr_q + CW'(1);
  assign keep   = (rd_seq_q == seq_q) || (rd_addr_q == self_addr_i);

  // select read and write ports
  always_comb begin
    rsel       = ptr_q;
    we         = 1'b0;
    waddr      = ptr_q[IW-1:0];
    wdata_addr = rd_addr_q;
    wdata_seq  = rd_seq_q;
    case (cmd_i)
      spat_pkg::CMD_RD_PREV: rsel = ptr_m1;
      spat_pkg::CMD_RD_NEXT: rsel = ptr_p1;
      spat_pkg::CMD_SH_WR,
      spat_pkg::CMD_RM_WR:   we = 1'b1;
      spat_pkg::CMD_INS_WR: begin
        we         = 1'b1;
        waddr      = pos_q[IW-1:0];
        wdata_addr = addr_q;
        wdata_seq  = seq_q;
      end
      spat_pkg::CMD_CL_WR: begin
        we        = keep;
        waddr     = wptr_q[IW-1:0];
        wdata_seq = seq_q;
      end
      default: ;
    endcase
  end
  assign raddr = rsel[IW-1:0];

  // entry memory with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_addr[waddr] <= wdata_addr;
      mem_seq[waddr]  <= wdata_seq;
    end
    rd_addr_q <= mem_addr[raddr];
    rd_seq_q  <= mem_seq[raddr];
  end

  // track the first entry
  always_ff @(posedge clk_i) begin
    if (we && waddr == '0) begin
      head_q <= wdata_addr;
    end
  end

  // latch operands and collect the result
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      spat_pkg::CMD_LOAD: begin
        kind_q    <= kind_i;
        addr_q    <= address_i;
        seq_q     <= seq_i;
        idx_q     <= entry_index_i;
        hit_q     <= 1'b0;
        hit_idx_q <= '0;
        hit_seq_q <= '0;
        limit_q   <= 1'b0;
        if (kind_i != spat_pkg::KindNext) begin
          next_q <= '0;
        end else if (count_q == '0) begin
          next_q <= address_i;
        end else begin
          next_q <= head_q;
        end
      end
      spat_pkg::CMD_HIT: begin
        hit_q     <= 1'b1;
        hit_idx_q <= ptr_q[IW-1:0];
        hit_seq_q <= rd_seq_q;
      end
      spat_pkg::CMD_SET_NEXT: next_q  <= rd_addr_q;
      spat_pkg::CMD_LIMIT:    limit_q <= 1'b1;
      spat_pkg::CMD_SET_POS:  pos_q   <= ptr_q;
      default: ;
    endcase
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      wptr_q  <= '0;
      count_q <= '0;
    end else begin
      case (cmd_i)
        spat_pkg::CMD_LOAD: begin
          ptr_q  <= (kind_i == spat_pkg::KindRemove) ? CW'(entry_index_i) : '0;
          wptr_q <= '0;
        end
        spat_pkg::CMD_PTR_INC: ptr_q <= ptr_p1;
        spat_pkg::CMD_SET_POS: ptr_q <= count_q;
        spat_pkg::CMD_SH_WR:   ptr_q <= ptr_m1;
        spat_pkg::CMD_RM_WR:   ptr_q <= ptr_p1;
        spat_pkg::CMD_INS_WR:  count_q <= count_q + CW'(1);
        spat_pkg::CMD_DEC:     count_q <= count_q - CW'(1);
        spat_pkg::CMD_CL_WR: begin
          ptr_q <= ptr_p1;
          if (keep) begin
            wptr_q <= wptr_q + CW'(1);
          end
        end
        spat_pkg::CMD_CL_END:  count_q <= wptr_q;
        default: ;
      endcase
    end
  end

  // status toward the sequencer
  always_comb begin
    status_o.kind     = kind_q;
    status_o.full     = (count_q == CW'(MaxPeers));
    status_o.reserved = (addr_q == warm_addr_i) || (addr_q == bcast_addr_i);
    status_o.at_end   = (ptr_q == count_q);
    status_o.ptr_last = ({1'b0, ptr_q} + {{CW{1'b0}}, 1'b1}) >= {1'b0, count_q};
    status_o.idx_bad  = (CW'(idx_q) >= count_q);
    status_o.addr_eq  = (rd_addr_q == addr_q);
    status_o.addr_lt  = (addr_q < rd_addr_q);
    status_o.at_pos   = (ptr_q == pos_q);
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= finish_i;
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (finish_i) begin
      status_bit_o    <= limit_q;
      hit_o           <= hit_q;
      hit_index_o     <= hit_idx_q;
      hit_seq_o       <= hit_seq_q;
      next_address_o  <= next_q;
      entry_total_o   <= count_q;
      is_full_o       <= (count_q == CW'(MaxPeers));
      is_empty_o      <= (count_q == '0);
      self_dominant_o <= (count_q != '0) && (head_q == self_addr_i);
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/core/spat_ctrl.sv
// ----------------------------------------------------------------------------
// spat_ctrl: operation sequencer
// Walks the entry memory for each operation by issuing one datapath command
// per cycle, reading back compare flags.
// ----------------------------------------------------------------------------
module spat_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  output spat_pkg::dp_cmd_e    cmd_o,
  output logic                 finish_o,
  input  spat_pkg::dp_status_t status_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SHIFT,
    ST_SHIFT_WR,
    ST_RM,
    ST_RM_WR,
    ST_FIND_RD,
    ST_FIND_EV,
    ST_NEXT_EV,
    ST_CL_RD,
    ST_CL_EV,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  // next state and command
  always_comb begin
    state_d  = state_q;
    cmd_o    = spat_pkg::CMD_IDLE;
    finish_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o   = spat_pkg::CMD_LOAD;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.kind)
          spat_pkg::KindInsert: begin
            if (status_i.full) begin
              cmd_o   = spat_pkg::CMD_LIMIT;
              state_d = ST_DONE;
            end else if (status_i.reserved) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_SCAN_RD;
            end
          end
          spat_pkg::KindRemove: begin
            if (status_i.idx_bad) begin
              cmd_o   = spat_pkg::CMD_LIMIT;
              state_d = ST_DONE;
            end else begin
              state_d = ST_RM;
            end
          end
          spat_pkg::KindLookup,
          spat_pkg::KindNext:  state_d = ST_FIND_RD;
          spat_pkg::KindClean: state_d = ST_CL_RD;
          default:             state_d = ST_DONE;
        endcase
      end
      ST_SCAN_RD: begin
        if (status_i.at_end) begin
          cmd_o   = spat_pkg::CMD_SET_POS;
          state_d = ST_SHIFT;
        end else begin
          cmd_o   = spat_pkg::CMD_RD_PTR;
          state_d = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        if (status_i.addr_eq) begin
          state_d = ST_DONE;
        end else if (status_i.addr_lt) begin
          cmd_o   = spat_pkg::CMD_SET_POS;
          state_d = ST_SHIFT;
        end else begin
          cmd_o   = spat_pkg::CMD_PTR_INC;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SHIFT: begin
        if (status_i.at_pos) begin
          cmd_o   = spat_pkg::CMD_INS_WR;
          state_d = ST_DONE;
        end else begin
          cmd_o   = spat_pkg::CMD_RD_PREV;
          state_d = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o   = spat_pkg::CMD_SH_WR;
        state_d = ST_SHIFT;
      end
      ST_RM: begin
        if (status_i.ptr_last) begin
          cmd_o   = spat_pkg::CMD_DEC;
          state_d = ST_DONE;
        end else begin
          cmd_o   = spat_pkg::CMD_RD_NEXT;
          state_d = ST_RM_WR;
        end
      end
      ST_RM_WR: begin
        cmd_o   = spat_pkg::CMD_RM_WR;
        state_d = ST_RM;
      end
      ST_FIND_RD: begin
        if (status_i.at_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o   = spat_pkg::CMD_RD_PTR;
          state_d = ST_FIND_EV;
        end
      end
      ST_FIND_EV: begin
        if (!status_i.addr_eq) begin
          cmd_o   = spat_pkg::CMD_PTR_INC;
          state_d = ST_FIND_RD;
        end else if (status_i.kind == spat_pkg::KindLookup) begin
          cmd_o   = spat_pkg::CMD_HIT;
          state_d = ST_DONE;
        end else if (status_i.ptr_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o   = spat_pkg::CMD_RD_NEXT;
          state_d = ST_NEXT_EV;
        end
      end
      ST_NEXT_EV: begin
        cmd_o   = spat_pkg::CMD_SET_NEXT;
        state_d = ST_DONE;
      end
      ST_CL_RD: begin
        if (status_i.at_end) begin
          cmd_o   = spat_pkg::CMD_CL_END;
          state_d = ST_DONE;
        end else begin
          cmd_o   = spat_pkg::CMD_RD_PTR;
          state_d = ST_CL_EV;
        end
      end
      ST_CL_EV: begin
        cmd_o   = spat_pkg::CMD_CL_WR;
        state_d = ST_CL_RD;
      end
      ST_DONE: begin
        finish_o = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // hold state and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

FILE: rtl/core/sorted_peer_address_table.sv
// ----------------------------------------------------------------------------
// sorted_peer_address_table: sorted peer address table
// Keeps up to MaxPeers (address, sequence) entries in ascending address order.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind_i, address_i, seq_i and entry_index_i with
//   start high; the command is taken on a clock edge where busy is low.
//   Busy rises the next cycle and stays high until the result beat.
//   Result: done_o pulses for one cycle with all result fields; the receiver
//   must take it then, as there is no back-pressure.
//   Config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 self, 1 warmboot,
//   2 broadcast) and cfg_data_i; ready is always high, write only when idle.
//   Sequencing: the sequencer reads each entry it touches and then evaluates
//   or writes it (one registered read port). Lookup/next scan until the match
//   or the end; a next whose match is not the last entry also reads the entry
//   after it. Insert scans for its position, then shifts later entries up one
//   place; a duplicate stops at its position, and a full table or reserved
//   address ends at dispatch. Remove shifts the entries after the index down;
//   clean walks every entry. A new command is taken in the beat cycle.
//   Reset empties the table and loads self 0, warmboot 0, broadcast all ones.
// ----------------------------------------------------------------------------
module sorted_peer_address_table #(
  parameter int unsigned MaxPeers = spat_pkg::MaxPeers,
  localparam int unsigned IW = $clog2(MaxPeers),
  localparam int unsigned CW = $clog2(MaxPeers + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [spat_pkg::KindWidth-1:0]    kind_i,
  input  logic [spat_pkg::AddrWidth-1:0]    address_i,
  input  logic [spat_pkg::SeqWidth-1:0]     seq_i,
  input  logic [IW-1:0]                     entry_index_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spat_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [spat_pkg::AddrWidth-1:0]    cfg_data_i,
  output logic                              done_o,
  output logic                              status_o,
  output logic                              hit_o,
  output logic [IW-1:0]                     hit_index_o,
  output logic [spat_pkg::SeqWidth-1:0]     hit_seq_o,
  output logic [spat_pkg::AddrWidth-1:0]    next_address_o,
  output logic [CW-1:0]                     entry_total_o,
  output logic                              is_full_o,
  output logic                              is_empty_o,
  output logic                              self_dominant_o
);

  logic [spat_pkg::AddrWidth-1:0] self_q, warm_q, bcast_q;
  spat_pkg::dp_cmd_e              cmd;
  spat_pkg::dp_status_t           dp_status;
  logic                           finish;

  assign cfg_ready_o = 1'b1;

  // hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q  <= '0;
      warm_q  <= '0;
      bcast_q <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spat_pkg::CfgSelf:      self_q  <= cfg_data_i;
        spat_pkg::CfgWarmboot:  warm_q  <= cfg_data_i;
        spat_pkg::CfgBroadcast: bcast_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spat_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_o    (cmd),
    .finish_o (finish),
    .status_i (dp_status)
  );

  spat_datapath #(
    .MaxPeers (MaxPeers)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .finish_i        (finish),
    .status_o        (dp_status),
    .kind_i          (kind_i),
    .address_i       (address_i),
    .seq_i           (seq_i),
    .entry_index_i   (entry_index_i),
    .self_addr_i     (self_q),
    .warm_addr_i     (warm_q),
    .bcast_addr_i    (bcast_q),
    .done_o          (done_o),
    .status_bit_o    (status_o),
    .hit_o           (hit_o),
    .hit_index_o     (hit_index_o),
    .hit_seq_o       (hit_seq_o),
    .next_address_o  (next_address_o),
    .entry_total_o   (entry_total_o),
    .is_full_o       (is_full_o),
    .is_empty_o      (is_empty_o),
    .self_dominant_o (self_dominant_o)
  );

  // a taken command keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after command");

  // the result beat comes when the sequencer has gone idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  // one beat per command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beat repeated");

  // reported count stays within the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (entry_total_o <= CW'(MaxPeers)))
    else $error("entry count beyond table size");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: sorted peer address table check
// A table of directed commands and then random command streams are driven
// into the table. A model of the sorted table in the bench predicts every
// result beat, and each beat is compared field by field. Self, warmboot and
// broadcast addresses are rewritten between phases while the table is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MaxPeers = spat_pkg::MaxPeers;
  localparam int unsigned KW = spat_pkg::KindWidth;
  localparam int unsigned AW = spat_pkg::AddrWidth;
  localparam int unsigned SW = spat_pkg::SeqWidth;
  localparam int unsigned XW = spat_pkg::CfgIdxWidth;
  localparam int unsigned IW = $clog2(MaxPeers);
  localparam int unsigned CW = $clog2(MaxPeers + 1);
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 4 * MaxPeers + 8;

  typedef struct packed {
    logic [KW-1:0] kind;
    logic [AW-1:0] address;
    logic [SW-1:0] seq;
    logic [IW-1:0] entry_index;
  } command_t;

  typedef struct packed {
    logic          status;
    logic          hit;
    logic [IW-1:0] hit_index;
    logic [SW-1:0] hit_seq;
    logic [AW-1:0] next_address;
    logic [CW-1:0] entry_total;
    logic          is_full;
    logic          is_empty;
    logic          self_dominant;
  } outcome_t;

  // directed row: command, plus an optional hand-typed outcome
  typedef struct packed {
    command_t cmd;
    logic     typed;
    outcome_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KW-1:0] kind_i = '0;
  logic [AW-1:0] address_i = '0;
  logic [SW-1:0] seq_i = '0;
  logic [IW-1:0] entry_index_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [XW-1:0] cfg_index_i = '0;
  logic [AW-1:0] cfg_data_i = '0;
  logic done_o, status_o, hit_o, is_full_o, is_empty_o, self_dominant_o;
  logic [IW-1:0] hit_index_o;
  logic [SW-1:0] hit_seq_o;
  logic [AW-1:0] next_address_o;
  logic [CW-1:0] entry_total_o;

  sorted_peer_address_table dut (.*);

  always #2 clk_i = ~clk_i;

  // table mirror
  logic [AW-1:0] peer_addr [MaxPeers];
  logic [SW-1:0] peer_seq  [MaxPeers];
  int unsigned   peer_count;
  logic [AW-1:0] self_reg, warm_reg, bcast_reg;

  outcome_t pending_outcomes [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;

  function automatic int find_peer(logic [AW-1:0] a);
    for (int i = 0; i < peer_count; i++) if (peer_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic void drop_peer(int pos);
    for (int i = pos; i + 1 < peer_count; i++) begin
      peer_addr[i] = peer_addr[i + 1];
      peer_seq[i] = peer_seq[i + 1];
    end
    peer_count--;
  endfunction

  // apply one command to the mirror and return the result beat it gives
  function automatic outcome_t apply_command(command_t c);
    outcome_t o;
    int f;
    int pos;
    int i;
    o = '0;
    case (c.kind)
      spat_pkg::KindInsert: begin
        if (peer_count >= MaxPeers) begin
          o.status = 1'b1;
        end else if (c.address != warm_reg && c.address != bcast_reg &&
                     find_peer(c.address) < 0) begin
          pos = peer_count;
          for (i = 0; i < peer_count; i++)
            if (c.address < peer_addr[i]) begin
              pos = i;
              break;
            end
          for (i = peer_count; i > pos; i--) begin
            peer_addr[i] = peer_addr[i - 1];
            peer_seq[i] = peer_seq[i - 1];
          end
          peer_addr[pos] = c.address;
          peer_seq[pos] = c.seq;
          peer_count++;
        end
      end
      spat_pkg::KindRemove: begin
        if (c.entry_index < peer_count) drop_peer(c.entry_index);
        else o.status = 1'b1;
      end
      spat_pkg::KindLookup: begin
        f = find_peer(c.address);
        if (f >= 0) begin
          o.hit = 1'b1;
          o.hit_index = IW'(f);
          o.hit_seq = peer_seq[f];
        end
      end
      spat_pkg::KindNext: begin
        if (peer_count == 0) begin
          o.next_address = c.address;
        end else begin
          o.next_address = peer_addr[0];
          f = find_peer(c.address);
          if (f >= 0 && f + 1 < peer_count) o.next_address = peer_addr[f + 1];
        end
      end
      spat_pkg::KindClean: begin
        i = 0;
        while (i < peer_count) begin
          if (peer_seq[i] != c.seq) begin
            if (peer_addr[i] == self_reg) begin
              peer_seq[i] = c.seq;
              i++;
            end else begin
              drop_peer(i);
            end
          end else begin
            i++;
          end
        end
      end
      default: ;
    endcase
    o.entry_total = CW'(peer_count);
    o.is_full = (peer_count == MaxPeers);
    o.is_empty = (peer_count == 0);
    o.self_dominant = (peer_count > 0) && (peer_addr[0] == self_reg);
    return o;
  endfunction

  // check result beats against the oldest expectation
  always @(posedge clk_i) begin
    outcome_t got, exp_o;
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) begin
      got = '{status_o, hit_o, hit_index_o, hit_seq_o, next_address_o,
              entry_total_o, is_full_o, is_empty_o, self_dominant_o};
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (got !== exp_o) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %h got %h", exp_o, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_register(logic [XW-1:0] idx, logic [AW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      spat_pkg::CfgSelf: self_reg = val;
      spat_pkg::CfgWarmboot: warm_reg = val;
      default: bcast_reg = val;
    endcase
  endtask

  // drive one command beat, optionally with a typed expectation
  task automatic send_command(command_t c, logic typed, outcome_t want);
    outcome_t pred;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk_i);
    start <= 1'b1;
    kind_i <= c.kind;
    address_i <= c.address;
    seq_i <= c.seq;
    entry_index_i <= c.entry_index;
    do @(posedge clk_i); while (busy);
    pred = apply_command(c);
    if (typed && pred !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("table row: expected %h model %h", want, pred);
    end
    pending_outcomes.push_back(typed ? want : pred);
    start <= 1'b0;
    // let busy rise before the next command is offered
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // pick an address likely to hit the table or the reserved values
  function automatic logic [AW-1:0] pick_address();
    case ($urandom_range(9))
      0, 1, 2: return (peer_count > 0) ? peer_addr[$urandom_range(peer_count - 1)] : $urandom();
      3: return self_reg;
      4: return warm_reg;
      5: return bcast_reg;
      6: return $urandom_range(40);
      7: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int n);
    command_t c;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      c.kind = (r < 40) ? spat_pkg::KindInsert : (r < 55) ? spat_pkg::KindRemove :
               (r < 72) ? spat_pkg::KindLookup : (r < 88) ? spat_pkg::KindNext :
               (r < 96) ? spat_pkg::KindClean : KW'($urandom_range(5, 7));
      c.address = pick_address();
      c.seq = ($urandom_range(3) == 0) ? SW'($urandom()) : SW'($urandom_range(2));
      c.entry_index = (peer_count > 0 && $urandom_range(1)) ?
                      IW'($urandom_range(peer_count - 1)) : IW'($urandom());
      send_command(c, 1'b0, '0);
    end
  endtask

  row_t directed [$];

  function automatic outcome_t plain(logic st, int total, logic [AW-1:0] nxt);
    outcome_t o;
    o = '0;
    o.status = st;
    o.next_address = nxt;
    o.entry_total = CW'(total);
    o.is_full = (total == MaxPeers);
    o.is_empty = (total == 0);
    return o;
  endfunction

  initial begin
    for (int i = 0; i < MaxPeers; i++) begin
      peer_addr[i] = '0;
      peer_seq[i] = '0;
    end
    peer_count = 0;
    self_reg = '0;
    warm_reg = '0;
    bcast_reg = '1;

    // after reset: empty table, reserved addresses dropped, bad index
    directed.push_back('{'{spat_pkg::KindNext, 32'h1234_5678, 8'h00, 4'd0}, 1'b1,
                        plain(1'b0, 0, 32'h1234_5678)});
    directed.push_back('{'{spat_pkg::KindInsert, 32'h0, 8'h11, 4'd0}, 1'b1,
                        plain(1'b0, 0, 0)});
    directed.push_back('{'{spat_pkg::KindInsert, 32'hFFFF_FFFF, 8'h11, 4'd0}, 1'b1,
                        plain(1'b0, 0, 0)});
    directed.push_back('{'{spat_pkg::KindRemove, 32'h0, 8'h00, 4'd15}, 1'b1,
                        plain(1'b1, 0, 0)});
    directed.push_back('{'{spat_pkg::KindLookup, 32'h5, 8'h00, 4'd0}, 1'b1,
                        plain(1'b0, 0, 0)});
    directed.push_back('{'{spat_pkg::KindInsert, 32'hFFFF_FFFE, 8'hFF, 4'd0}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindInsert, 32'h1, 8'h00, 4'd0}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindInsert, 32'h8000_0000, 8'hA5, 4'd0}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindInsert, 32'h1, 8'h77, 4'd0}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindLookup, 32'h8000_0000, 8'h00, 4'd0}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindNext, 32'hFFFF_FFFE, 8'h00, 4'd0}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindNext, 32'h1, 8'h00, 4'd0}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindNext, 32'h2, 8'h00, 4'd0}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindRemove, 32'h0, 8'h00, 4'd1}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindRemove, 32'h0, 8'h00, 4'd2}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindClean, 32'h0, 8'hFF, 4'd0}, 1'b0, '0});
    directed.push_back('{'{KW'(7), 32'hFFFF_FFFF, 8'hFF, 4'd15}, 1'b0, '0});
    directed.push_back('{'{spat_pkg::KindClean, 32'h0, 8'h00, 4'd0}, 1'b0, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_command(directed[i].cmd, directed[i].typed, directed[i].want);

    // fill to full, then insert on a full table; self at 0 is dominant
    wait_idle();
    write_register(spat_pkg::CfgWarmboot, 32'hFFFF_FFFF);
    write_register(spat_pkg::CfgBroadcast, 32'h0000_0001);
    write_register(spat_pkg::CfgSelf, 32'h0);
    for (int k = 0; k <= MaxPeers + 1; k++)
      send_command('{spat_pkg::KindInsert, AW'(k * 3), SW'(k), IW'(0)}, 1'b0, '0);
    send_command('{spat_pkg::KindClean, 32'h0, 8'h05, 4'd0}, 1'b0, '0);

    // random phases with different register settings and idle mixes
    send_idle_pct = 16;
    random_phase(300);
    wait_idle();
    write_register(spat_pkg::CfgSelf, 32'hFFFF_FFFF);
    write_register(spat_pkg::CfgWarmboot, $urandom());
    write_register(spat_pkg::CfgBroadcast, 32'd7);
    send_idle_pct = 45;
    random_phase(300);
    wait_idle();
    write_register(spat_pkg::CfgSelf, $urandom_range(20));
    write_register(spat_pkg::CfgWarmboot, 32'h0);
    write_register(spat_pkg::CfgBroadcast, 32'hFFFF_FFFF);
    send_idle_pct = 0;
    random_phase(300);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/spat_pkg.sv
rtl/core/spat_datapath.sv
rtl/core/spat_ctrl.sv
rtl/core/sorted_peer_address_table.sv
test/testbench.sv
